/* hdl/bqb_pkg.sv */
package bqb_pkg;

  // Number of button channels that are processed, and the hold counter width.
  localparam int CHANNELS    = 16;
  localparam int COUNT_WIDTH = 8;

  // Fixed widths of the transaction fields and configuration registers.
  localparam int WORD_WIDTH  = 16;
  localparam int LIMIT_WIDTH = 8;
  localparam int CFG_WIDTH   = 64;
  localparam int CFG_IDX_W   = 2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Channel modes; the unused code behaves as push.
  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_IMPULSE = 2'd1,
    MODE_TOGGLE  = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODES       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_HIGH = 2'd2;

  // Reset values: channel 5 toggles with a limit of 5, channels 6 and 7 give
  // impulses, every other channel is push with a limit of 2.
  localparam logic [31:0] MODES_RESET       = 32'h0000_5800;
  localparam logic [63:0] LIMITS_LOW_RESET  = 64'h0202_0502_0202_0202;
  localparam logic [63:0] LIMITS_HIGH_RESET = 64'h0202_0202_0202_0202;

  // Control group handed from the top level to each lane.
  typedef struct packed {
    logic   advance;
    logic   level;
    mode_t  mode;
    count_t limit;
  } lane_ctl_t;

  // A limit byte reduced to the counter width.
  function automatic count_t limit_of(input logic [LIMIT_WIDTH-1:0] b);
    logic [LIMIT_WIDTH+COUNT_WIDTH-1:0] ext;
    begin
      ext = {{COUNT_WIDTH{1'b0}}, b};
      limit_of = ext[COUNT_WIDTH-1:0];
    end
  endfunction

endpackage

/* hdl/bqb_in_if.sv */
interface bqb_in_if;
  logic                           valid;
  logic                           ready;
  logic [bqb_pkg::WORD_WIDTH-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

/* hdl/bqb_out_if.sv */
interface bqb_out_if;
  logic                           valid;
  logic                           ready;
  logic [bqb_pkg::WORD_WIDTH-1:0] button_word;

  modport source (output valid, output button_word, input ready);
  modport sink   (input valid, input button_word, output ready);
endinterface

/* hdl/bqb_lane.sv */
module bqb_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  bqb_pkg::lane_ctl_t ctl,
  output logic               bit_nxt
);

  bqb_pkg::count_t cnt_r;
  bqb_pkg::count_t cnt_nxt;
  logic            state_r;
  logic            fire;
  logic            cnt_eq;

  // Counter and qualified bit for the coming tick.
  always_comb begin
    cnt_nxt = cnt_r;
    fire    = 1'b0;
    cnt_eq  = 1'b0;
    bit_nxt = state_r;
    case (ctl.mode)
      bqb_pkg::MODE_IMPULSE, bqb_pkg::MODE_TOGGLE: begin
        // The counter stops one past the limit so a long hold fires once.
        if (!ctl.level) begin
          cnt_nxt = '0;
          fire    = (ctl.limit == '0);
        end else if (cnt_r <= ctl.limit && cnt_r != bqb_pkg::COUNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
          fire    = (cnt_nxt == ctl.limit);
        end
        if (ctl.mode == bqb_pkg::MODE_IMPULSE) begin
          bit_nxt = fire;
        end else begin
          bit_nxt = state_r ^ fire;
        end
      end
      default: begin
        // Push: count up to the limit and show 1 while sitting on it.
        if (!ctl.level) begin
          cnt_nxt = '0;
        end else if (cnt_r < ctl.limit) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        cnt_eq  = (cnt_nxt == ctl.limit);
        bit_nxt = cnt_eq;
      end
    endcase
  end

  // State advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      state_r <= 1'b0;
    end else if (ctl.advance) begin
      cnt_r   <= cnt_nxt;
      state_r <= bit_nxt;
    end
  end

endmodule

/* hdl/bqb_merge.sv */
module bqb_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [bqb_pkg::WORD_WIDTH-1:0] lane_bits,
  output logic                           stall,
  bqb_out_if.source                      out_chan
);

  logic                           valid_r;
  logic [bqb_pkg::WORD_WIDTH-1:0] word_r;

  // The register is full and the receiver is not taking it this cycle.
  assign stall = valid_r && !out_chan.ready;

  // Output register: gathers the lane bits into one word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= lane_bits;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.button_word = word_r;

endmodule

/* hdl/button_qualifier_bank.sv */
// Button qualifier bank: sixteen debounced button channels sharing one tick.
//
// in_chan carries one transaction per tick: button_levels, one raw level per
// channel. out_chan returns one transaction per input transaction:
// button_word, the qualified state of every channel after that tick.
// Both channels use valid/ready; a transaction moves when both are high.
// The result is registered and appears in the cycle after its input is
// accepted; unless out_chan stalls, the sustained rate is one transaction
// per cycle, set by the single output register behind the per-channel lanes.
// While the receiver holds out_chan.ready low with a result waiting, in_chan
// ready drops and all counters hold; nothing is lost or repeated.
// The cfg port writes channel_modes (index 0), limits_low (1) and
// limits_high (2) on any cycle with cfg_we high; other indexes are ignored.
// Write configuration only while the block is idle.
// After the synchronous reset (rst_n low) all hold counters and state bits
// are zero, the registers take their default values and no result is
// pending; the block accepts input on the first cycle after reset.
module button_qualifier_bank (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bqb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bqb_pkg::CFG_WIDTH-1:0]  cfg_wdata,
  bqb_in_if.sink                         in_chan,
  bqb_out_if.source                      out_chan
);

  logic [31:0]                    modes_r;
  logic [63:0]                    limits_low_r;
  logic [63:0]                    limits_high_r;
  logic [127:0]                   limits_all;
  logic                           stall;
  logic                           advance;
  logic [bqb_pkg::WORD_WIDTH-1:0] lane_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r       <= bqb_pkg::MODES_RESET;
      limits_low_r  <= bqb_pkg::LIMITS_LOW_RESET;
      limits_high_r <= bqb_pkg::LIMITS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bqb_pkg::REG_MODES:       modes_r       <= cfg_wdata[31:0];
        bqb_pkg::REG_LIMITS_LOW:  limits_low_r  <= cfg_wdata;
        bqb_pkg::REG_LIMITS_HIGH: limits_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign limits_all = {limits_high_r, limits_low_r};

  // Input handshake: accept whenever the output register can move on.
  assign in_chan.ready = !stall;
  assign advance       = in_chan.valid && !stall;

  // One lane per processed channel; any other bit stays at zero.
  for (genvar i = 0; i < bqb_pkg::WORD_WIDTH; i++) begin : g_lane
    if (i < bqb_pkg::CHANNELS) begin : g_on
      bqb_pkg::lane_ctl_t ctl;

      assign ctl.advance = advance;
      assign ctl.level   = in_chan.button_levels[i];
      assign ctl.mode    = bqb_pkg::mode_t'(modes_r[2*i +: 2]);
      assign ctl.limit   = bqb_pkg::limit_of(limits_all[8*i +: 8]);

      bqb_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .bit_nxt (lane_bits[i])
      );
    end else begin : g_off
      assign lane_bits[i] = 1'b0;
    end
  end

  // Merge the lane bits into the result word.
  bqb_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .lane_bits (lane_bits),
    .stall     (stall),
    .out_chan  (out_chan)
  );

endmodule

/* tb/tb_button_qualifier_bank.sv */
module tb_button_qualifier_bank;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bqb_pkg::WORD_WIDTH-1:0] word_t;

  // Expected button words, worked out from the raw levels of every accepted tick.
  class qualifier_scoreboard;
    logic [31:0]     mode_bits;
    logic [63:0]     limits_lo;
    logic [63:0]     limits_hi;
    bqb_pkg::count_t hold[bqb_pkg::WORD_WIDTH];
    word_t           qual_bits;
    word_t           expected_words[$];
    int              errors;

    function new();
      mode_bits = bqb_pkg::MODES_RESET;
      limits_lo = bqb_pkg::LIMITS_LOW_RESET;
      limits_hi = bqb_pkg::LIMITS_HIGH_RESET;
      foreach (hold[i]) hold[i] = '0;
      qual_bits = '0;
      errors    = 0;
    endfunction

    function void write_reg(input logic [bqb_pkg::CFG_IDX_W-1:0] idx,
                            input logic [bqb_pkg::CFG_WIDTH-1:0] d);
      case (idx)
        bqb_pkg::REG_MODES:       mode_bits = d[31:0];
        bqb_pkg::REG_LIMITS_LOW:  limits_lo = d;
        bqb_pkg::REG_LIMITS_HIGH: limits_hi = d;
        default: ;
      endcase
    endfunction

    // Advance every channel by one tick and queue the resulting word.
    function void note_input(input word_t levels);
      bqb_pkg::mode_t                  m;
      logic [bqb_pkg::LIMIT_WIDTH-1:0] lim_byte;
      bqb_pkg::count_t                 lim;
      bqb_pkg::count_t                 cnt;
      logic                            fire;
      for (int i = 0; i < bqb_pkg::CHANNELS && i < bqb_pkg::WORD_WIDTH; i++) begin
        m        = bqb_pkg::mode_t'(mode_bits[2*i +: 2]);
        lim_byte = (i < 8) ? limits_lo[8*i +: 8] : limits_hi[8*(i-8) +: 8];
        lim      = bqb_pkg::count_t'(lim_byte);
        cnt      = hold[i];
        case (m)
          bqb_pkg::MODE_IMPULSE, bqb_pkg::MODE_TOGGLE: begin
            // The counter stops one past the limit, so a long hold fires once.
            fire = 1'b0;
            if (!levels[i]) begin
              cnt  = '0;
              fire = (lim == '0);
            end else if (cnt <= lim && cnt < bqb_pkg::COUNT_MAX) begin
              cnt  = cnt + 1'b1;
              fire = (cnt == lim);
            end
            if (m == bqb_pkg::MODE_IMPULSE) qual_bits[i] = fire;
            else if (fire)                  qual_bits[i] = ~qual_bits[i];
          end
          default: begin
            // Push, and the unused mode code, which behaves as push.
            if (!levels[i])     cnt = '0;
            else if (cnt < lim) cnt = cnt + 1'b1;
            qual_bits[i] = (cnt == lim);
          end
        endcase
        hold[i] = cnt;
      end
      expected_words.push_back(qual_bits);
    endfunction

    function void check_result(input word_t word);
      word_t exp_word;
      if (expected_words.size() == 0) begin
        $display("%0t: button_word %h arrived with nothing expected", $time, word);
        errors++;
      end else begin
        exp_word = expected_words.pop_front();
        if (word !== exp_word) begin
          $display("%0t: button_word mismatch, expected %h, actual %h", $time, exp_word, word);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  typedef enum {STYLE_NOISE, STYLE_SPARSE, STYLE_HOLD} level_style_t;

  // Directed ticks against the reset settings: limits reached, overrun, toggling.
  localparam word_t DIRECTED_LEVELS [20] = '{
    16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555,
    16'h5555, 16'h5555, 16'h0000, 16'hFFFF, 16'h7FFF, 16'hFFFE
  };

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [bqb_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [bqb_pkg::CFG_WIDTH-1:0]       cfg_wdata;
  bit                                  steady_flow;
  word_t                               cur_levels;

  bqb_in_if  in_bus();
  bqb_out_if out_bus();

  qualifier_scoreboard sb = new();

  button_qualifier_bank dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  always #2 clk = ~clk;

  // The receiver stalls at random except during a steady stretch.
  always @(negedge clk) begin
    out_bus.ready = steady_flow || ($urandom_range(0, 99) >= 36);
  end

  // Note accepted ticks and check returned words at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) sb.note_input(in_bus.button_levels);
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.button_word);
    end
  end

  // Offer one tick of levels, with a random gap first, and wait for acceptance.
  task automatic send_levels(input word_t levels);
    while (!steady_flow && $urandom_range(0, 99) < 36) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid         = 1'b1;
    in_bus.button_levels = levels;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Wait until every expected word has come back, then let the pipeline settle.
  task automatic drain_results();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [bqb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bqb_pkg::CFG_WIDTH-1:0] d);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [63:0] small_limits(input int top);
    logic [63:0] v;
    for (int b = 0; b < 8; b++) v[8*b +: 8] = 8'($urandom_range(0, top));
    return v;
  endfunction

  // Next tick of levels: pure noise, sparse changes, or long holds with short drops.
  function automatic word_t next_levels(input word_t cur, input level_style_t style);
    case (style)
      STYLE_SPARSE: begin
        if ($urandom_range(0, 9) == 0) return word_t'($urandom);
        return cur ^ word_t'($urandom & $urandom & $urandom);
      end
      STYLE_HOLD: begin
        if ($urandom_range(0, 99) < 4)
          return ~(word_t'(1) << $urandom_range(0, bqb_pkg::WORD_WIDTH - 1));
        return '1;
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  // One phase: settle, write all three registers, then stream ticks.
  task automatic run_phase(input logic [31:0] modes, input logic [63:0] lo,
                           input logic [63:0] hi, input int n_items,
                           input level_style_t style, input bit steady);
    drain_results();
    write_cfg(bqb_pkg::REG_MODES, {32'h0, modes});
    write_cfg(bqb_pkg::REG_LIMITS_LOW, lo);
    write_cfg(bqb_pkg::REG_LIMITS_HIGH, hi);
    steady_flow = steady;
    for (int k = 0; k < n_items; k++) begin
      cur_levels = next_levels(cur_levels, style);
      send_levels(cur_levels);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = bqb_pkg::REG_MODES;
    cfg_wdata            = '0;
    steady_flow          = 1'b0;
    cur_levels           = '0;
    in_bus.valid         = 1'b0;
    in_bus.button_levels = '0;
    out_bus.ready        = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings first, driven by hand.
    foreach (DIRECTED_LEVELS[k]) send_levels(DIRECTED_LEVELS[k]);
    run_phase(bqb_pkg::MODES_RESET, bqb_pkg::LIMITS_LOW_RESET, bqb_pkg::LIMITS_HIGH_RESET,
              40, STYLE_SPARSE, 1'b0);

    // Limits of zero in each mode, then the unused mode code everywhere.
    run_phase(32'h0000_0000, '0, '0, 20, STYLE_NOISE, 1'b0);
    run_phase(32'h5555_5555, '0, '0, 20, STYLE_NOISE, 1'b0);
    run_phase(32'hAAAA_AAAA, '0, '0, 20, STYLE_NOISE, 1'b0);
    run_phase(32'hFFFF_FFFF, small_limits(6), small_limits(6), 30, STYLE_SPARSE, 1'b0);

    // Long holds up to the counter's maximum, with no stalls on either side.
    run_phase($urandom, '1, 64'hFEFE_FEFE_FEFE_FEFE, 300, STYLE_HOLD, 1'b1);

    // Lowered limits while counters are still high from the long holds.
    run_phase($urandom, small_limits(4), small_limits(4), 30, STYLE_HOLD, 1'b0);

    // Random settings with mostly small limits.
    run_phase($urandom, small_limits(7), small_limits(7), 30, STYLE_SPARSE, 1'b0);
    run_phase($urandom, small_limits(3), small_limits(3), 30, STYLE_SPARSE, 1'b1);
    run_phase($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 30, STYLE_SPARSE, 1'b0);
    run_phase($urandom, small_limits(5), small_limits(5), 30, STYLE_NOISE, 1'b0);

    drain_results();
    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Ends a run that has hung.
  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
